// ===== sv/sdtq_pkg.sv =====
// shared types and constants for the sorted deadline timer queue
`timescale 1ns / 1ps
`default_nettype none
package sdtq_pkg;

    // operation codes
    localparam logic [1:0] FUNC_ADD     = 2'd0;
    localparam logic [1:0] FUNC_REFRESH = 2'd1;
    localparam logic [1:0] FUNC_FREE    = 2'd2;
    localparam logic [1:0] FUNC_EXPIRE  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_EXPIRED = 2'd1;
    localparam logic [1:0] KIND_NONE    = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_NOFREE  = 2'd2;
    localparam logic [1:0] ST_BADH    = 2'd3;

    localparam logic [45:0] NS_PER_SEC = 46'd1000000000;
    localparam logic [36:0] NS_PER_MS  = 37'd1000000;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  handle;
        logic [31:0] user_tag;
        logic [15:0] delay_sec;
        logic [15:0] delay_ms;
        logic [62:0] now_ns;
    } req_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  timer_id;
        logic [31:0] tag_out;
        logic [1:0]  status;
        logic        rearm;
        logic [62:0] next_deadline_ns;
        logic        last;
    } rsp_word_t;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       take_nh;
        logic       tag_wr;
        logic       alloc_clr;
        logic       div_init;
        logic       div_step;
        logic       mul1;
        logic       mul2;
        logic       sum;
        logic       scan_clr;
        logic       scan_inc;
        logic       rm_shift;
        logic       ins_shift;
        logic       pop;
        logic       prog_head;
        logic       prog_exp;
        logic       emit;
        logic [1:0] kind;
        logic [1:0] status;
        logic       id_zero;
        logic       use_head;
        logic       last;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] func;
        logic       zero;
        logic       h_valid;
        logic       full;
        logic       pending;
        logic       due;
        logic       le_d;
        logic       hne;
        logic       in_range;
        logic       div_done;
        logic       out_free;
        logic       scan_one;
        logic       scan_zero;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== sv/sdtq_datapath.sv =====
// timer list, handle pool, deadline arithmetic and result register
`timescale 1ns / 1ps
`default_nettype none
module sdtq_datapath #(
    parameter int NUM_TIMERS      = 16,
    parameter int MIN_INTERVAL_MS = 100
) (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  sdtq_pkg::req_word_t      req_in,
    input  sdtq_pkg::ctl_cmd_t       cmd,
    output sdtq_pkg::dp_stat_t       stat,
    output logic                     rsp_valid,
    input  wire                logic rsp_ready,
    output sdtq_pkg::rsp_word_t      rsp_out
);
    localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W  = $clog2(NUM_TIMERS + 1);
    localparam int NUM_W  = 17;
    // reciprocal of the minimum interval, exact for every 17-bit numerator
    localparam int     RCP_SH = NUM_W + $clog2(MIN_INTERVAL_MS);
    localparam int     RP_W   = RCP_SH + NUM_W;
    localparam longint RCP_M  = ((longint'(1) << RCP_SH) + longint'(MIN_INTERVAL_MS) - 1)
                                / longint'(MIN_INTERVAL_MS);

    logic [62:0]      dl_list_reg  [NUM_TIMERS];
    logic [IDX_W-1:0] hnd_list_reg [NUM_TIMERS];
    logic [31:0]      tag_mem_reg  [NUM_TIMERS];
    logic [CNT_W-1:0] count_reg;
    logic [NUM_TIMERS-1:0] alloc_reg;
    logic [NUM_TIMERS-1:0] pend_reg;
    logic [62:0]      prog_reg;
    logic [62:0]      before_reg;
    sdtq_pkg::req_word_t word_reg;
    logic [IDX_W-1:0] cur_idx_reg;
    logic             h_ok_reg;
    logic [CNT_W-1:0] scan_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] q_reg;
    logic             q_done_reg;
    logic [16:0]      msa_reg;
    logic [45:0]      secns_reg;
    logic [36:0]      msns_reg;
    logic [63:0]      acc_reg;
    logic [62:0]      dl_reg;
    logic             rsp_valid_reg;
    sdtq_pkg::rsp_word_t rsp_reg;

    logic [6:0]       h_wide;
    logic [IDX_W-1:0] nh;
    logic [IDX_W-1:0] rd_idx;
    logic [62:0]      rd_dl;
    logic             in_range;
    logic [RP_W-1:0]  rcp_prod;
    logic [63:0]      dsum;
    logic [6:0]       id_wide;
    logic [IDX_W-1:0] head_h;

    // handle decode of the incoming word
    assign h_wide = {3'b000, req_in.handle};

    // lowest free handle
    always_comb
    begin
        nh = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
        begin
            if (!alloc_reg[i])
            begin
                nh = IDX_W'(i);
            end
        end
    end

    // scan read port
    assign rd_idx   = scan_reg[IDX_W-1:0];
    assign in_range = scan_reg < count_reg;
    assign rd_dl    = dl_list_reg[rd_idx];
    assign head_h   = hnd_list_reg[0];

    // round-up quotient by reciprocal multiply and final sum
    assign rcp_prod = RP_W'(num_reg) * RP_W'(RCP_M);
    assign dsum     = acc_reg + 64'(msns_reg);

    // status to the controller
    always_comb
    begin
        stat.func      = word_reg.func;
        stat.zero      = (word_reg.delay_sec == 16'd0) && (word_reg.delay_ms == 16'd0);
        stat.h_valid   = h_ok_reg && alloc_reg[cur_idx_reg];
        stat.full      = &alloc_reg;
        stat.pending   = pend_reg[cur_idx_reg];
        stat.due       = in_range && (rd_dl <= word_reg.now_ns);
        stat.le_d      = in_range && (rd_dl <= dl_reg);
        stat.hne       = in_range && (hnd_list_reg[rd_idx] != cur_idx_reg);
        stat.in_range  = in_range;
        stat.div_done  = q_done_reg;
        stat.out_free  = !rsp_valid_reg || rsp_ready;
        stat.scan_one  = scan_reg == CNT_W'(1);
        stat.scan_zero = scan_reg == '0;
    end

    // input latch, arithmetic and scan counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg   <= '0;
            q_done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                word_reg    <= req_in;
                before_reg  <= prog_reg;
                h_ok_reg    <= h_wide < 7'(NUM_TIMERS);
                cur_idx_reg <= h_wide[IDX_W-1:0];
            end
            else if (cmd.take_nh)
            begin
                cur_idx_reg <= nh;
            end
            if (cmd.div_init)
            begin
                num_reg    <= NUM_W'(word_reg.delay_ms) + NUM_W'(MIN_INTERVAL_MS - 1);
                q_done_reg <= 1'b0;
            end
            else if (cmd.div_step)
            begin
                q_reg      <= rcp_prod[RCP_SH +: NUM_W];
                q_done_reg <= 1'b1;
            end
            if (cmd.mul1)
            begin
                msa_reg   <= 17'(q_reg * 17'(MIN_INTERVAL_MS));
                secns_reg <= 46'(word_reg.delay_sec) * sdtq_pkg::NS_PER_SEC;
            end
            if (cmd.mul2)
            begin
                msns_reg <= 37'(msa_reg) * sdtq_pkg::NS_PER_MS;
                acc_reg  <= 64'(word_reg.now_ns) + 64'(secns_reg);
            end
            if (cmd.sum)
            begin
                dl_reg <= dsum[63] ? {63{1'b1}} : dsum[62:0];
            end
            priority if (cmd.scan_clr)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_inc)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            else if (cmd.pop)
            begin
                scan_reg <= scan_reg - 1'b1;
            end
        end
    end

    // timer list, pool masks and programmed deadline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            alloc_reg <= '0;
            pend_reg  <= '0;
            prog_reg  <= '0;
        end
        else
        begin
            if (cmd.take_nh)
            begin
                alloc_reg[nh]   <= 1'b1;
                tag_mem_reg[nh] <= word_reg.user_tag;
            end
            if (cmd.tag_wr)
            begin
                tag_mem_reg[cur_idx_reg] <= word_reg.user_tag;
            end
            if (cmd.alloc_clr)
            begin
                alloc_reg[cur_idx_reg] <= 1'b0;
            end
            priority if (cmd.rm_shift)
            begin
                for (int i = 0; i < NUM_TIMERS - 1; i++)
                begin
                    if (CNT_W'(i) >= scan_reg)
                    begin
                        dl_list_reg[i]  <= dl_list_reg[i+1];
                        hnd_list_reg[i] <= hnd_list_reg[i+1];
                    end
                end
                count_reg <= count_reg - 1'b1;
                pend_reg[cur_idx_reg] <= 1'b0;
            end
            else if (cmd.ins_shift)
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (CNT_W'(i) == scan_reg)
                    begin
                        dl_list_reg[i]  <= dl_reg;
                        hnd_list_reg[i] <= cur_idx_reg;
                    end
                    else if ((i > 0) && (CNT_W'(i) > scan_reg))
                    begin
                        dl_list_reg[i]  <= dl_list_reg[(i > 0) ? i - 1 : 0];
                        hnd_list_reg[i] <= hnd_list_reg[(i > 0) ? i - 1 : 0];
                    end
                end
                count_reg <= count_reg + 1'b1;
                pend_reg[cur_idx_reg] <= 1'b1;
            end
            else if (cmd.pop)
            begin
                for (int i = 0; i < NUM_TIMERS - 1; i++)
                begin
                    dl_list_reg[i]  <= dl_list_reg[i+1];
                    hnd_list_reg[i] <= hnd_list_reg[i+1];
                end
                count_reg <= count_reg - 1'b1;
                pend_reg[head_h] <= 1'b0;
            end
            priority if (cmd.prog_head && (count_reg != '0))
            begin
                prog_reg <= dl_list_reg[0];
            end
            else if (cmd.prog_exp && in_range)
            begin
                prog_reg <= rd_dl;
            end
        end
    end

    // result register
    always_comb
    begin
        priority if (cmd.id_zero)
        begin
            id_wide = '0;
        end
        else if (cmd.use_head)
        begin
            id_wide = 7'(head_h);
        end
        else if (word_reg.func == sdtq_pkg::FUNC_ADD)
        begin
            id_wide = 7'(cur_idx_reg);
        end
        else
        begin
            id_wide = 7'(word_reg.handle);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                rsp_valid_reg            <= 1'b1;
                rsp_reg.kind             <= cmd.kind;
                rsp_reg.timer_id         <= id_wide[3:0];
                rsp_reg.tag_out          <= cmd.use_head ? tag_mem_reg[head_h] : 32'd0;
                rsp_reg.status           <= cmd.status;
                rsp_reg.rearm            <= prog_reg != before_reg;
                rsp_reg.next_deadline_ns <= prog_reg;
                rsp_reg.last             <= cmd.last;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_out   = rsp_reg;

    // list bookkeeping checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(NUM_TIMERS))
        else $error("queue count beyond pool size");
    a_pend_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg & ~alloc_reg) == '0)
        else $error("pending timer not allocated");
    a_pend_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(pend_reg) == int'(count_reg))
        else $error("pending mask disagrees with queue count");

endmodule
`default_nettype wire

// ===== sv/sdtq_ctrl.sv =====
// sequencing state machine for the timer queue
`timescale 1ns / 1ps
`default_nettype none
module sdtq_ctrl (
    input  wire               logic clk,
    input  wire               logic rst_n,
    input  wire               logic req_valid,
    output logic                    req_ready,
    input  sdtq_pkg::dp_stat_t      stat,
    output sdtq_pkg::ctl_cmd_t      cmd
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_DIV      = 4'd2;
    localparam logic [3:0] S_MUL1     = 4'd3;
    localparam logic [3:0] S_MUL2     = 4'd4;
    localparam logic [3:0] S_SUM      = 4'd5;
    localparam logic [3:0] S_RM_SCAN  = 4'd6;
    localparam logic [3:0] S_RM_SHIFT = 4'd7;
    localparam logic [3:0] S_IN_SCAN  = 4'd8;
    localparam logic [3:0] S_IN_SHIFT = 4'd9;
    localparam logic [3:0] S_PROG     = 4'd10;
    localparam logic [3:0] S_ACK      = 4'd11;
    localparam logic [3:0] S_EX_SCAN  = 4'd12;
    localparam logic [3:0] S_EX_POP   = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [1:0] kind_reg, kind_next;
    logic [1:0] st_reg, st_next;
    logic       idz_reg, idz_next;

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        st_next    = st_reg;
        idz_next   = idz_reg;
        cmd        = '0;
        req_ready  = state_reg == S_IDLE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                kind_next = sdtq_pkg::KIND_ACK;
                st_next   = sdtq_pkg::ST_OK;
                idz_next  = 1'b0;
                unique case (stat.func)
                    sdtq_pkg::FUNC_ADD:
                    begin
                        if (stat.zero)
                        begin
                            st_next    = sdtq_pkg::ST_ZERO;
                            idz_next   = 1'b1;
                            state_next = S_ACK;
                        end
                        else if (stat.full)
                        begin
                            st_next    = sdtq_pkg::ST_NOFREE;
                            idz_next   = 1'b1;
                            state_next = S_ACK;
                        end
                        else
                        begin
                            cmd.take_nh  = 1'b1;
                            cmd.div_init = 1'b1;
                            state_next   = S_DIV;
                        end
                    end
                    sdtq_pkg::FUNC_REFRESH:
                    begin
                        if (!stat.h_valid)
                        begin
                            st_next    = sdtq_pkg::ST_BADH;
                            state_next = S_ACK;
                        end
                        else if (stat.zero)
                        begin
                            st_next    = sdtq_pkg::ST_ZERO;
                            state_next = S_ACK;
                        end
                        else
                        begin
                            cmd.tag_wr   = 1'b1;
                            cmd.div_init = 1'b1;
                            state_next   = S_DIV;
                        end
                    end
                    sdtq_pkg::FUNC_FREE:
                    begin
                        if (!stat.h_valid)
                        begin
                            st_next    = sdtq_pkg::ST_BADH;
                            state_next = S_ACK;
                        end
                        else
                        begin
                            // a pending handle is released together with its list entry
                            cmd.alloc_clr = !stat.pending;
                            cmd.scan_clr  = 1'b1;
                            state_next    = stat.pending ? S_RM_SCAN : S_ACK;
                        end
                    end
                    sdtq_pkg::FUNC_EXPIRE:
                    begin
                        cmd.scan_clr = 1'b1;
                        state_next   = S_EX_SCAN;
                    end
                endcase
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_MUL1;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum      = 1'b1;
                cmd.scan_clr = 1'b1;
                state_next   = stat.pending ? S_RM_SCAN : S_IN_SCAN;
            end
            S_RM_SCAN:
            begin
                priority if (stat.hne)
                begin
                    cmd.scan_inc = 1'b1;
                end
                else if (stat.in_range)
                begin
                    state_next = S_RM_SHIFT;
                end
                else if (stat.func == sdtq_pkg::FUNC_REFRESH)
                begin
                    cmd.scan_clr = 1'b1;
                    state_next   = S_IN_SCAN;
                end
                else
                begin
                    cmd.alloc_clr = 1'b1;
                    state_next    = S_PROG;
                end
            end
            S_RM_SHIFT:
            begin
                cmd.rm_shift = 1'b1;
                if (stat.func == sdtq_pkg::FUNC_REFRESH)
                begin
                    // insertion scans again from the head
                    cmd.scan_clr = 1'b1;
                    state_next   = S_IN_SCAN;
                end
                else
                begin
                    cmd.alloc_clr = 1'b1;
                    state_next    = S_PROG;
                end
            end
            S_IN_SCAN:
            begin
                if (stat.le_d)
                begin
                    cmd.scan_inc = 1'b1;
                end
                else
                begin
                    state_next = S_IN_SHIFT;
                end
            end
            S_IN_SHIFT:
            begin
                cmd.ins_shift = 1'b1;
                state_next    = S_PROG;
            end
            S_PROG:
            begin
                cmd.prog_head = 1'b1;
                state_next    = S_ACK;
            end
            S_ACK:
            begin
                if (stat.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.kind    = kind_reg;
                    cmd.status  = st_reg;
                    cmd.id_zero = idz_reg;
                    cmd.last    = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_EX_SCAN:
            begin
                if (stat.due)
                begin
                    cmd.scan_inc = 1'b1;
                end
                else
                begin
                    cmd.prog_exp = 1'b1;
                    if (stat.scan_zero)
                    begin
                        kind_next  = sdtq_pkg::KIND_NONE;
                        st_next    = sdtq_pkg::ST_OK;
                        idz_next   = 1'b1;
                        state_next = S_ACK;
                    end
                    else
                    begin
                        state_next = S_EX_POP;
                    end
                end
            end
            S_EX_POP:
            begin
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.kind     = sdtq_pkg::KIND_EXPIRED;
                    cmd.status   = sdtq_pkg::ST_OK;
                    cmd.use_head = 1'b1;
                    cmd.last     = stat.scan_one;
                    cmd.pop      = 1'b1;
                    if (stat.scan_one)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and pending acknowledge fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= sdtq_pkg::KIND_ACK;
            st_reg    <= sdtq_pkg::ST_OK;
            idz_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            st_reg    <= st_next;
            idz_reg   <= idz_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/sorted_deadline_timer_queue.sv =====
// top level of the sorted deadline timer queue
// Usage:
//  req channel (req_valid/req_ready/req_word) takes one operation word:
//  add, refresh, free or expire check. rsp channel (rsp_valid/rsp_ready/
//  rsp_word) returns one word per operation, or one per expired timer on an
//  expire check; the final word of an operation has last set.
//  Steps per operation:
//   add/refresh: a reciprocal multiply for the millisecond round-up, two
//   multiply stages, a sum, then a list scan and shift for removal (refresh
//   of a queued timer) and insertion, one list entry compared per cycle
//   free: the result word alone, or a list scan and shift when queued
//   expire: a scan for due timers, then a pop and a result word per due
//   timer, or one word of kind none when nothing is due
//   errors and zero delays: the result word alone
//  One operation is in flight at a time; req_ready is high only while the
//  sequencer is idle. A result word sits in an output register, so the next
//  operation is taken while it waits. When the receiver stalls, the
//  sequencer holds before emitting the next word.
//  Reset empties the pool and the list and clears the programmed deadline;
//  no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module sorted_deadline_timer_queue #(
    parameter int NUM_TIMERS      = 16,
    parameter int MIN_INTERVAL_MS = 100
) (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire                logic req_valid,
    output logic                     req_ready,
    input  sdtq_pkg::req_word_t      req_word,
    output logic                     rsp_valid,
    input  wire                logic rsp_ready,
    output sdtq_pkg::rsp_word_t      rsp_word
);
    sdtq_pkg::ctl_cmd_t cmd;
    sdtq_pkg::dp_stat_t stat;

    sdtq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sdtq_datapath #(
        .NUM_TIMERS      (NUM_TIMERS),
        .MIN_INTERVAL_MS (MIN_INTERVAL_MS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_in    (req_word),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_out   (rsp_word)
    );

endmodule
`default_nettype wire

// ===== test/sdtq_checker.sv =====
// checker for the sorted deadline timer queue: predicts result words and compares them
`timescale 1ns / 1ps
module sdtq_checker
    import sdtq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    input  wire logic      req_ready,
    input  req_word_t      req_word,
    input  wire logic      rsp_valid,
    input  wire logic      rsp_ready,
    input  rsp_word_t      rsp_word,
    output int             fail_count,
    output int             pending_words
);

    localparam int NT = 16;
    localparam int MIN_MS = 100;
    localparam logic [62:0] T63_MAX = {63{1'b1}};

    // predictor state
    logic [62:0] dl_list [NT];
    logic [3:0]  ord_h   [NT];
    int          qcount;
    logic [15:0] alloc_m;
    logic [15:0] pend_m;
    logic [31:0] tags    [NT];
    logic [62:0] prog_dl;

    rsp_word_t expected_words[$];

    assign pending_words = expected_words.size();

    function automatic logic [62:0] deadline_of(logic [62:0] now, logic [15:0] sec,
                                                logic [15:0] ms);
        logic [127:0] aligned;
        logic [127:0] d;
        begin
            aligned = ((128'(ms) + MIN_MS - 1) / MIN_MS) * MIN_MS;
            d = 128'(now) + 128'(sec) * 128'd1000000000 + aligned * 128'd1000000;
            if (d > 128'(T63_MAX))
                d = 128'(T63_MAX);
            return d[62:0];
        end
    endfunction

    task automatic drop_handle(logic [3:0] h);
        int pos;
        begin
            pos = qcount;
            for (int i = 0; i < qcount; i++)
                if (ord_h[i] == h && pos == qcount)
                    pos = i;
            if (pos < qcount) begin
                for (int i = pos; i + 1 < qcount; i++) begin
                    dl_list[i] = dl_list[i + 1];
                    ord_h[i] = ord_h[i + 1];
                end
                qcount--;
                pend_m[h] = 1'b0;
            end
        end
    endtask

    task automatic place_handle(logic [3:0] h, logic [62:0] d);
        int pos;
        begin
            pos = 0;
            while (pos < qcount && dl_list[pos] <= d)
                pos++;
            for (int i = qcount; i > pos; i--) begin
                dl_list[i] = dl_list[i - 1];
                ord_h[i] = ord_h[i - 1];
            end
            dl_list[pos] = d;
            ord_h[pos] = h;
            qcount++;
            pend_m[h] = 1'b1;
            if (dl_list[0] != prog_dl)
                prog_dl = dl_list[0];
        end
    endtask

    function automatic rsp_word_t word_of(logic [1:0] k, logic [3:0] id, logic [31:0] tg,
                                          logic [1:0] st);
        rsp_word_t w;
        begin
            w = '0;
            w.kind = k;
            w.timer_id = id;
            w.tag_out = tg;
            w.status = st;
            return w;
        end
    endfunction

    // work out the result words of one operation word
    task automatic predict_op(req_word_t rq);
        rsp_word_t   outw[$];
        logic [62:0] prev;
        logic        zero;
        logic        hvalid;
        int          nh;
        logic [3:0]  eh;
        begin
            prev = prog_dl;
            zero = (rq.delay_sec == 0) && (rq.delay_ms == 0);
            hvalid = alloc_m[rq.handle];
            case (rq.func)
                FUNC_ADD: begin
                    if (zero)
                        outw.push_back(word_of(KIND_ACK, 4'd0, 32'd0, ST_ZERO));
                    else if (&alloc_m)
                        outw.push_back(word_of(KIND_ACK, 4'd0, 32'd0, ST_NOFREE));
                    else begin
                        nh = 0;
                        while (alloc_m[nh])
                            nh++;
                        alloc_m[nh] = 1'b1;
                        tags[nh] = rq.user_tag;
                        place_handle(4'(nh), deadline_of(rq.now_ns, rq.delay_sec,
                                                         rq.delay_ms));
                        outw.push_back(word_of(KIND_ACK, 4'(nh), 32'd0, ST_OK));
                    end
                end
                FUNC_REFRESH: begin
                    if (!hvalid)
                        outw.push_back(word_of(KIND_ACK, rq.handle, 32'd0, ST_BADH));
                    else if (zero)
                        outw.push_back(word_of(KIND_ACK, rq.handle, 32'd0, ST_ZERO));
                    else begin
                        drop_handle(rq.handle);
                        tags[rq.handle] = rq.user_tag;
                        place_handle(rq.handle, deadline_of(rq.now_ns, rq.delay_sec,
                                                            rq.delay_ms));
                        outw.push_back(word_of(KIND_ACK, rq.handle, 32'd0, ST_OK));
                    end
                end
                FUNC_FREE: begin
                    if (!hvalid)
                        outw.push_back(word_of(KIND_ACK, rq.handle, 32'd0, ST_BADH));
                    else begin
                        if (pend_m[rq.handle]) begin
                            drop_handle(rq.handle);
                            if (qcount > 0 && dl_list[0] != prog_dl)
                                prog_dl = dl_list[0];
                        end
                        alloc_m[rq.handle] = 1'b0;
                        outw.push_back(word_of(KIND_ACK, rq.handle, 32'd0, ST_OK));
                    end
                end
                default: begin
                    while (qcount > 0 && dl_list[0] <= rq.now_ns && outw.size() < NT) begin
                        eh = ord_h[0];
                        outw.push_back(word_of(KIND_EXPIRED, eh, tags[eh], ST_OK));
                        drop_handle(eh);
                    end
                    if (qcount > 0)
                        prog_dl = dl_list[0];
                    if (outw.size() == 0)
                        outw.push_back(word_of(KIND_NONE, 4'd0, 32'd0, ST_OK));
                end
            endcase
            foreach (outw[k]) begin
                outw[k].rearm = (prog_dl != prev);
                outw[k].next_deadline_ns = prog_dl;
                outw[k].last = (k == outw.size() - 1);
                expected_words.push_back(outw[k]);
            end
        end
    endtask

    // watch both channels
    always @(posedge clk or negedge rst_n)
    begin
        rsp_word_t want;
        if (!rst_n)
        begin
            qcount = 0;
            alloc_m = '0;
            pend_m = '0;
            prog_dl = '0;
            fail_count = 0;
            expected_words.delete();
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected word %h", $time, rsp_word);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (want !== rsp_word)
                    begin
                        fail_count++;
                        $display("%0t: mismatch expected %p actual %p", $time, want, rsp_word);
                    end
                end
            end
            if (req_valid && req_ready)
                predict_op(req_word);
        end
    end

endmodule

// ===== test/tb.sv =====
// testbench top for the sorted deadline timer queue: stimulus and verdict
`timescale 1ns / 1ps
module tb;

    localparam int WATCH_LIMIT = 20000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    sdtq_pkg::req_word_t req_word = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    sdtq_pkg::rsp_word_t rsp_word;
    int        fail_count;
    int        pending_words;

    int        send_idle_pct = 35;
    int        recv_idle_pct = 80;
    logic      recv_hold = 1'b0;
    logic [62:0] clock_ns = 63'd1000;
    int        idle_cycles = 0;

    always #1 clk = ~clk;

    sorted_deadline_timer_queue DUT (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
    );

    sdtq_checker CHK (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
        .fail_count(fail_count), .pending_words(pending_words)
    );

    // receiver readiness
    always @(posedge clk)
        rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

    // watchdog on accepted words
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // offer one word and wait for its acceptance; valid drops at the next pause
    task automatic send_word(sdtq_pkg::req_word_t w);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
            req_valid <= 1'b1;
            req_word <= w;
            @(posedge clk);
            while (!req_ready)
                @(posedge clk);
        end
    endtask

    task automatic send_op(logic [1:0] f, logic [3:0] h, logic [15:0] sec,
                           logic [15:0] ms, logic [62:0] now);
        sdtq_pkg::req_word_t w;
        begin
            w.func = f;
            w.handle = h;
            w.user_tag = $urandom;
            w.delay_sec = sec;
            w.delay_ms = ms;
            w.now_ns = now;
            send_word(w);
        end
    endtask

    // random operation mix, mostly small delays around a rising clock
    task automatic random_op;
        int r;
        logic [15:0] sec;
        logic [15:0] ms;
        logic [62:0] now;
        begin
            r = $urandom_range(99);
            clock_ns = clock_ns + 63'($urandom_range(400000000));
            now = clock_ns;
            sec = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1));
            ms = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1500));
            if ($urandom_range(19) == 0)
            begin
                sec = 0;
                ms = 0;
            end
            if ($urandom_range(29) == 0)
                now = {1'b1, 62'($urandom) << 30 | 62'($urandom)};
            if (r < 35)
                send_op(sdtq_pkg::FUNC_ADD, 4'($urandom), sec, ms, now);
            else if (r < 50)
                send_op(sdtq_pkg::FUNC_REFRESH, 4'($urandom), sec, ms, now);
            else if (r < 65)
                send_op(sdtq_pkg::FUNC_FREE, 4'($urandom), sec, ms, now);
            else
                send_op(sdtq_pkg::FUNC_EXPIRE, 4'($urandom), sec, ms, now);
        end
    endtask

    task automatic drain;
        begin
            req_valid <= 1'b0;
            while (pending_words != 0)
                @(posedge clk);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes and each special case
        send_op(sdtq_pkg::FUNC_EXPIRE, 4'd0, 16'd0, 16'd0, 63'd0);
        send_op(sdtq_pkg::FUNC_ADD, 4'd0, 16'd0, 16'd0, 63'd5);
        send_op(sdtq_pkg::FUNC_REFRESH, 4'd3, 16'd1, 16'd1, 63'd5);
        send_op(sdtq_pkg::FUNC_FREE, 4'd15, 16'd1, 16'd1, 63'd5);
        send_op(sdtq_pkg::FUNC_ADD, 4'd0, 16'hFFFF, 16'hFFFF, {63{1'b1}});
        send_op(sdtq_pkg::FUNC_ADD, 4'd0, 16'd0, 16'd1, 63'd100);
        send_op(sdtq_pkg::FUNC_ADD, 4'd0, 16'd0, 16'd100, 63'd100);
        send_op(sdtq_pkg::FUNC_ADD, 4'd0, 16'd0, 16'd101, 63'd0);
        send_op(sdtq_pkg::FUNC_REFRESH, 4'd1, 16'd0, 16'd0, 63'd0);
        send_op(sdtq_pkg::FUNC_REFRESH, 4'd1, 16'd2, 16'd0, 63'd0);
        send_op(sdtq_pkg::FUNC_FREE, 4'd2, 16'd0, 16'd0, 63'd0);
        for (int i = 0; i < 13; i++)
            send_op(sdtq_pkg::FUNC_ADD, 4'd0, 16'd0, 16'(i * 50 + 1), 63'd7);
        send_op(sdtq_pkg::FUNC_ADD, 4'd0, 16'd1, 16'd0, 63'd0);
        send_op(sdtq_pkg::FUNC_EXPIRE, 4'd0, 16'hFFFF, 16'hFFFF, 63'd3000000000);
        send_op(sdtq_pkg::FUNC_EXPIRE, 4'd0, 16'd0, 16'd0, {63{1'b1}});
        for (int h = 0; h < 16; h++)
            send_op(sdtq_pkg::FUNC_FREE, 4'(h), 16'd0, 16'd0, 63'd0);
        drain();

        // long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        recv_hold <= 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                recv_hold <= 1'b0;
            end
            begin
                for (int i = 0; i < 20; i++)
                    random_op();
                req_valid <= 1'b0;
            end
        join

        // random phases with different idling
        send_idle_pct = 35;
        recv_idle_pct = 80;
        for (int i = 0; i < 100; i++)
            random_op();
        send_idle_pct = 80;
        recv_idle_pct = 35;
        for (int i = 0; i < 100; i++)
            random_op();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 100; i++)
            random_op();

        drain();
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending_words == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sdtq_pkg.sv
sv/sdtq_datapath.sv
sv/sdtq_ctrl.sv
sv/sorted_deadline_timer_queue.sv
test/sdtq_checker.sv
test/tb.sv
